@@ design/c8x_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c8x_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StUnsup = 2'd1,
    StOver  = 2'd2,
    StUnder = 2'd3
  } status_e;

  // Whole-word opcodes of the system family.
  localparam logic [15:0] OpCls = 16'h00E0;
  localparam logic [15:0] OpRet = 16'h00EE;

  // Program counter value after reset.
  localparam logic [11:0] StartReset = 12'h200;

  // Flag register number.
  localparam logic [3:0] RegFlag = 4'hF;

  // Instruction families (top nibble).
  localparam logic [3:0] FamSys       = 4'h0;
  localparam logic [3:0] FamJump      = 4'h1;
  localparam logic [3:0] FamCall      = 4'h2;
  localparam logic [3:0] FamSkipEqImm = 4'h3;
  localparam logic [3:0] FamSkipNeImm = 4'h4;
  localparam logic [3:0] FamSkipEqReg = 4'h5;
  localparam logic [3:0] FamLoadImm   = 4'h6;
  localparam logic [3:0] FamAddImm    = 4'h7;
  localparam logic [3:0] FamAlu       = 4'h8;
  localparam logic [3:0] FamSkipNeReg = 4'h9;
  localparam logic [3:0] FamLoadIndex = 4'hA;
  localparam logic [3:0] FamJumpV0    = 4'hB;
  localparam logic [3:0] FamRandom    = 4'hC;

  // ALU group operations (low nibble of 8XYN).
  localparam logic [3:0] AluMov  = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  // Everything one executed instruction changes.
  typedef struct packed {
    logic [11:0] pc;
    logic [11:0] index;
    logic        cls;
    logic        x_en;
    logic [7:0]  x_val;
    logic        f_en;
    logic        f_val;
    logic        push;
    logic        pop;
    logic [11:0] link;
    status_e     status;
  } exec_t;

endpackage

`default_nettype wire

@@ design/c8x_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decodes one instruction and computes all of its effects from the operands
// read out of the register file and the return stack.
module c8x_exec (
  input  wire logic [15:0]   instr_i,
  input  wire logic [7:0]    rnd_i,
  input  wire logic [7:0]    vx_i,
  input  wire logic [7:0]    vy_i,
  input  wire logic [11:0]   pc_i,
  input  wire logic [11:0]   index_i,
  input  wire logic          stk_empty_i,
  input  wire logic          stk_full_i,
  input  wire logic [11:0]   pop_pc_i,
  output c8x_pkg::exec_t     res_o
);

  logic [3:0]  fam;
  logic [3:0]  n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [11:0] pc_inc;
  logic [11:0] pc_skip;
  logic [8:0]  sum;

  assign fam     = instr_i[15:12];
  assign n       = instr_i[3:0];
  assign nn      = instr_i[7:0];
  assign nnn     = instr_i[11:0];
  assign pc_inc  = pc_i + 12'd2;
  assign pc_skip = pc_i + 12'd4;
  assign sum     = {1'b0, vx_i} + {1'b0, vy_i};

  // Main decode.
  always_comb begin
    res_o        = '0;
    res_o.pc     = pc_inc;
    res_o.index  = index_i;
    res_o.link   = pc_inc;
    res_o.status = c8x_pkg::StOk;
    unique case (fam)
      c8x_pkg::FamSys: begin
        if (instr_i == c8x_pkg::OpCls) begin
          res_o.cls = 1'b1;
        end else if (instr_i == c8x_pkg::OpRet) begin
          if (stk_empty_i) begin
            res_o.pc     = 12'd0;
            res_o.status = c8x_pkg::StUnder;
          end else begin
            res_o.pop = 1'b1;
            res_o.pc  = pop_pc_i;
          end
        end else begin
          res_o.status = c8x_pkg::StUnsup;
        end
      end
      c8x_pkg::FamJump: begin
        res_o.pc = nnn;
      end
      c8x_pkg::FamCall: begin
        // A call on a full stack still jumps; only the push is lost.
        if (stk_full_i) begin
          res_o.status = c8x_pkg::StOver;
        end else begin
          res_o.push = 1'b1;
        end
        res_o.pc = nnn;
      end
      c8x_pkg::FamSkipEqImm: res_o.pc = (vx_i == nn) ? pc_skip : pc_inc;
      c8x_pkg::FamSkipNeImm: res_o.pc = (vx_i != nn) ? pc_skip : pc_inc;
      c8x_pkg::FamSkipEqReg: res_o.pc = (vx_i == vy_i) ? pc_skip : pc_inc;
      c8x_pkg::FamSkipNeReg: res_o.pc = (vx_i != vy_i) ? pc_skip : pc_inc;
      c8x_pkg::FamLoadImm: begin
        res_o.x_en  = 1'b1;
        res_o.x_val = nn;
      end
      c8x_pkg::FamAddImm: begin
        res_o.x_en  = 1'b1;
        res_o.x_val = vx_i + nn;
      end
      c8x_pkg::FamAlu: begin
        res_o.x_en = 1'b1;
        unique case (n)
          c8x_pkg::AluMov: res_o.x_val = vy_i;
          c8x_pkg::AluOr:  res_o.x_val = vx_i | vy_i;
          c8x_pkg::AluAnd: res_o.x_val = vx_i & vy_i;
          c8x_pkg::AluXor: res_o.x_val = vx_i ^ vy_i;
          c8x_pkg::AluAdd: begin
            res_o.x_val = sum[7:0];
            res_o.f_en  = 1'b1;
            res_o.f_val = sum[8];
          end
          c8x_pkg::AluSub: begin
            res_o.x_val = vx_i - vy_i;
            res_o.f_en  = 1'b1;
            res_o.f_val = (vx_i >= vy_i);
          end
          c8x_pkg::AluShr: begin
            res_o.x_val = {1'b0, vx_i[7:1]};
            res_o.f_en  = 1'b1;
            res_o.f_val = vx_i[0];
          end
          c8x_pkg::AluSubn: begin
            res_o.x_val = vy_i - vx_i;
            res_o.f_en  = 1'b1;
            res_o.f_val = (vy_i >= vx_i);
          end
          c8x_pkg::AluShl: begin
            res_o.x_val = {vx_i[6:0], 1'b0};
            res_o.f_en  = 1'b1;
            res_o.f_val = vx_i[7];
          end
          default: begin
            res_o.x_en   = 1'b0;
            res_o.status = c8x_pkg::StUnsup;
          end
        endcase
      end
      c8x_pkg::FamLoadIndex: res_o.index = nnn;
      // The operand port carries V0 for this family.
      c8x_pkg::FamJumpV0: res_o.pc = {4'd0, vy_i} + nnn;
      c8x_pkg::FamRandom: begin
        res_o.x_en  = 1'b1;
        res_o.x_val = rnd_i & nn;
      end
      default: res_o.status = c8x_pkg::StUnsup;
    endcase
  end

endmodule

`default_nettype wire

@@ design/chip8_instruction_execute_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Executes CHIP-8 instructions of the 0x0 through 0xC families, one result per
// instruction. The unit sustains one instruction per clock while the output is
// not stalled: the register file and the return stack are synchronous memories
// read at the input transfer, and the instruction executes and writes back when
// it leaves the execute stage, which also loads the output register.
// Back-to-back dependent instructions are handled by forwarding from the
// write-back into the memory read registers. VF lives in its own register.
// The data registers read as zero after reset; the return stack holds no
// reset value and needs no clearing pass. A configuration transfer loads the
// program counter. It is held off while an instruction waits in execute and
// should only be issued while the unit is idle.
module chip8_instruction_execute_unit #(
  parameter int STACK_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] cfg_start_address_i,
  // Instruction input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] instruction_i,
  input  wire logic [7:0]  random_byte_i,
  // Result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      next_pc_o,
  output logic [11:0]      index_value_o,
  output logic             clear_screen_o,
  output logic             reg_write_valid_o,
  output logic [3:0]       reg_write_index_o,
  output logic [7:0]       reg_write_value_o,
  output logic [1:0]       status_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int AdrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Handshake and stage control.
  logic in_accept;
  logic exec_fire;
  logic exec_valid_q;
  logic out_valid_q;

  // Execute stage payload.
  logic [15:0] instr_q;
  logic [7:0]  rnd_q;
  logic [3:0]  in_x;
  logic [3:0]  in_y;
  logic [3:0]  ex_x;
  logic [3:0]  ex_y;

  // Register file memory and its read side.
  logic [7:0]  rf_mem [16];
  logic [15:0] rf_vld_q;
  logic [7:0]  rdx_q;
  logic [7:0]  rdy_q;
  logic        vldx_q;
  logic        vldy_q;
  logic        fwdx_q;
  logic        fwdy_q;
  logic [7:0]  fwd_val_q;
  logic        rf_we;
  logic [7:0]  vf_q;
  logic [7:0]  vx;
  logic [7:0]  vy;

  // Return stack memory and its read side.
  logic [11:0]     stk_mem [STACK_DEPTH];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic [CntW-1:0] cnt_m1;
  logic [AdrW-1:0] stk_ra;
  logic [AdrW-1:0] stk_wa;
  logic            stk_we;
  logic [11:0]     stk_rd_q;
  logic            stk_fwd_q;
  logic [11:0]     stk_fwd_val_q;
  logic [11:0]     pop_pc;

  // Architectural registers.
  logic [11:0] pc_q;
  logic [11:0] idx_q;

  // Output register.
  logic [11:0]      o_pc_q;
  logic [11:0]      o_idx_q;
  logic             o_cls_q;
  logic             o_wv_q;
  logic [3:0]       o_wi_q;
  logic [7:0]       o_wd_q;
  c8x_pkg::status_e o_st_q;

  c8x_pkg::exec_t res;

  // Handshakes: the execute stage moves on whenever the output slot frees.
  assign exec_fire   = exec_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !exec_valid_q || exec_fire;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = !exec_valid_q;

  // Operand addresses; the indexed jump reads V0 on the second port.
  assign in_x = instruction_i[11:8];
  assign in_y = (instruction_i[15:12] == c8x_pkg::FamJumpV0) ? 4'd0 : instruction_i[7:4];
  assign ex_x = instr_q[11:8];
  assign ex_y = (instr_q[15:12] == c8x_pkg::FamJumpV0) ? 4'd0 : instr_q[7:4];

  // Register file write-back; VF is kept outside the memory.
  assign rf_we = exec_fire && res.x_en && (ex_x != c8x_pkg::RegFlag);

  // Stack pointer update and read address for the next instruction.
  always_comb begin
    cnt_d = cnt_q;
    if (exec_fire && res.push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (exec_fire && res.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign cnt_m1 = cnt_d - CntW'(1);
  assign stk_ra = cnt_m1[AdrW-1:0];
  assign stk_wa = cnt_q[AdrW-1:0];
  assign stk_we = exec_fire && res.push;

  // Register file memory.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[ex_x] <= res.x_val;
    end
    if (in_accept) begin
      rdx_q <= rf_mem[in_x];
      rdy_q <= rf_mem[in_y];
    end
  end

  // Return stack memory.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= res.link;
    end
    if (in_accept) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  // Execute stage payload and forwarding from the write-back at the same edge.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q       <= instruction_i;
      rnd_q         <= random_byte_i;
      vldx_q        <= rf_vld_q[in_x];
      vldy_q        <= rf_vld_q[in_y];
      fwdx_q        <= rf_we && (ex_x == in_x);
      fwdy_q        <= rf_we && (ex_x == in_y);
      fwd_val_q     <= res.x_val;
      stk_fwd_q     <= stk_we && (stk_wa == stk_ra);
      stk_fwd_val_q <= res.link;
    end
  end

  // Operand selection: VF register, forwarded value, memory or reset zero.
  always_comb begin
    if (ex_x == c8x_pkg::RegFlag) begin
      vx = vf_q;
    end else if (fwdx_q) begin
      vx = fwd_val_q;
    end else begin
      vx = vldx_q ? rdx_q : 8'd0;
    end
    if (ex_y == c8x_pkg::RegFlag) begin
      vy = vf_q;
    end else if (fwdy_q) begin
      vy = fwd_val_q;
    end else begin
      vy = vldy_q ? rdy_q : 8'd0;
    end
  end

  assign pop_pc = stk_fwd_q ? stk_fwd_val_q : stk_rd_q;

  c8x_exec u_exec (
    .instr_i     (instr_q),
    .rnd_i       (rnd_q),
    .vx_i        (vx),
    .vy_i        (vy),
    .pc_i        (pc_q),
    .index_i     (idx_q),
    .stk_empty_i (cnt_q == '0),
    .stk_full_i  (cnt_q == CntW'(STACK_DEPTH)),
    .pop_pc_i    (pop_pc),
    .res_o       (res)
  );

  // Control state and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      rf_vld_q     <= '0;
      vf_q         <= 8'd0;
      cnt_q        <= '0;
      pc_q         <= c8x_pkg::StartReset;
      idx_q        <= 12'd0;
    end else begin
      if (in_accept) begin
        exec_valid_q <= 1'b1;
      end else if (exec_fire) begin
        exec_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[ex_x] <= 1'b1;
      end
      cnt_q <= cnt_d;
      if (exec_fire) begin
        pc_q  <= res.pc;
        idx_q <= res.index;
        if (res.f_en) begin
          vf_q <= {7'd0, res.f_val};
        end else if (res.x_en && (ex_x == c8x_pkg::RegFlag)) begin
          vf_q <= res.x_val;
        end
      end else if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= cfg_start_address_i;
      end
    end
  end

  // Output register; the flag write is reported over the Vx write.
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      o_pc_q  <= res.pc;
      o_idx_q <= res.index;
      o_cls_q <= res.cls;
      o_st_q  <= res.status;
      if (res.f_en) begin
        o_wv_q <= 1'b1;
        o_wi_q <= c8x_pkg::RegFlag;
        o_wd_q <= {7'd0, res.f_val};
      end else if (res.x_en) begin
        o_wv_q <= 1'b1;
        o_wi_q <= ex_x;
        o_wd_q <= res.x_val;
      end else begin
        o_wv_q <= 1'b0;
        o_wi_q <= 4'd0;
        o_wd_q <= 8'd0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = o_pc_q;
  assign index_value_o     = o_idx_q;
  assign clear_screen_o    = o_cls_q;
  assign reg_write_valid_o = o_wv_q;
  assign reg_write_index_o = o_wi_q;
  assign reg_write_value_o = o_wd_q;
  assign status_o          = o_st_q;

  // The stack pointer never passes the stack depth.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A push moves the stack pointer up by exactly one.
  a_push_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && res.push) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("push did not advance stack count");

  // Input is held off only while an instruction waits in execute.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (exec_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked execute stage");

  // A stack underflow result always points the program counter at zero.
  a_under_pc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == c8x_pkg::StUnder)) |-> (next_pc_o == 12'd0))
    else $error("underflow with nonzero program counter");

  // A pop is never issued on an empty stack.
  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && res.pop) |-> (cnt_q != '0))
    else $error("pop on empty stack");

endmodule

`default_nettype wire
